/* sv/hrd_pkg.sv */
// Shared types and constants for the HART response deframer.
// No dependencies; compile first.
package hrd_pkg;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
    localparam logic [7:0] DELIM_SHORT   = 8'h06;
    localparam logic [7:0] DELIM_LONG    = 8'h86;
    localparam logic [7:0] MIN_COUNT     = 8'd2;
    localparam logic [4:0] PREAMBLE_MAX  = 5'd31;
    localparam logic [4:0] MIN_PREAMBLE_RST = 5'd2;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_GAP  = 1'b1;

    localparam logic [2:0] VERDICT_OK     = 3'd0;
    localparam logic [2:0] VERDICT_SHORT  = 3'd1;
    localparam logic [2:0] VERDICT_BADLEN = 3'd2;
    localparam logic [2:0] VERDICT_CHKERR = 3'd3;
    localparam logic [2:0] VERDICT_TRUNC  = 3'd4;

    typedef enum logic [8:0] {
        PH_PRE   = 9'b000000001,
        PH_ADDR  = 9'b000000010,
        PH_CMD   = 9'b000000100,
        PH_COUNT = 9'b000001000,
        PH_ST1   = 9'b000010000,
        PH_ST2   = 9'b000100000,
        PH_DATA  = 9'b001000000,
        PH_CHK   = 9'b010000000,
        PH_DONE  = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] data_byte;
        logic [2:0] verdict;
        logic [7:0] command;
        logic [7:0] response_code;
        logic [7:0] device_status;
        logic [7:0] byte_count;
        logic [7:0] frame_delimiter;
        logic [7:0] short_address;
    } rsp_t;

endpackage

/* sv/hrd_if.sv */
// Channel interfaces: received bytes in, response items out.
// No dependencies.
interface hrd_rx_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface hrd_rsp_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] data_byte;
    logic [2:0] verdict;
    logic [7:0] command;
    logic [7:0] response_code;
    logic [7:0] device_status;
    logic [7:0] byte_count;
    logic [7:0] frame_delimiter;
    logic [7:0] short_address;

    modport source (
        output valid, output out_kind, output data_byte, output verdict,
        output command, output response_code, output device_status,
        output byte_count, output frame_delimiter, output short_address,
        input  ready
    );
    modport sink (
        input  valid, input out_kind, input data_byte, input verdict,
        input  command, input response_code, input device_status,
        input  byte_count, input frame_delimiter, input short_address,
        output ready
    );
endinterface

/* sv/hrd_parser.sv */
// Frame parser: per-byte state update and result generation.
// Depends on hrd_pkg.
module hrd_parser
    import hrd_pkg::*;
#(
    parameter int LONG_ADDRESS_BYTES = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [4:0] min_preamble,
    input  logic       accept,
    input  logic       req_type,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output rsp_t       res
);

    localparam int ADDR_LEFT_W = $clog2(LONG_ADDRESS_BYTES + 1);

    phase_t                 phase_reg,          phase_next;
    logic [4:0]             preamble_count_reg, preamble_count_next;
    logic [ADDR_LEFT_W-1:0] address_left_reg,   address_left_next;
    logic [7:0]             frame_start_reg,    frame_start_next;
    logic [7:0]             addr_byte_reg,      addr_byte_next;
    logic [7:0]             cmd_reg,            cmd_next;
    logic [7:0]             count_reg,          count_next;
    logic [7:0]             status_one_reg,     status_one_next;
    logic [7:0]             status_two_reg,     status_two_next;
    logic [7:0]             data_left_reg,      data_left_next;
    logic [7:0]             running_xor_reg,    running_xor_next;

    logic       emit;
    logic       emit_kind;
    logic [7:0] emit_data;
    logic [2:0] emit_verdict;

    always_comb
    begin
        phase_next          = phase_reg;
        preamble_count_next = preamble_count_reg;
        address_left_next   = address_left_reg;
        frame_start_next    = frame_start_reg;
        addr_byte_next      = addr_byte_reg;
        cmd_next            = cmd_reg;
        count_next          = count_reg;
        status_one_next     = status_one_reg;
        status_two_next     = status_two_reg;
        data_left_next      = data_left_reg;
        running_xor_next    = running_xor_reg;
        emit                = 1'b0;
        emit_kind           = KIND_VERDICT;
        emit_data           = 8'd0;
        emit_verdict        = VERDICT_OK;

        if (req_type == REQ_GAP)
        begin
            emit         = (phase_reg != PH_PRE) && (phase_reg != PH_DONE);
            emit_verdict = VERDICT_TRUNC;
        end
        else
        begin
            unique case (phase_reg)
                PH_PRE:
                begin
                    if (rx_byte == PREAMBLE_BYTE)
                    begin
                        if (preamble_count_reg < PREAMBLE_MAX)
                            preamble_count_next = preamble_count_reg + 5'd1;
                    end
                    else
                    begin
                        frame_start_next = rx_byte;
                        if (preamble_count_reg < min_preamble)
                        begin
                            phase_next   = PH_DONE;
                            emit         = 1'b1;
                            emit_verdict = VERDICT_SHORT;
                        end
                        else
                        begin
                            running_xor_next = rx_byte;
                            if (rx_byte == DELIM_SHORT)
                            begin
                                address_left_next = ADDR_LEFT_W'(1);
                                phase_next        = PH_ADDR;
                            end
                            else if (rx_byte == DELIM_LONG)
                            begin
                                address_left_next = ADDR_LEFT_W'(LONG_ADDRESS_BYTES);
                                phase_next        = PH_ADDR;
                            end
                            else
                            begin
                                address_left_next = '0;
                                phase_next        = PH_CMD;
                            end
                        end
                    end
                end
                PH_ADDR:
                begin
                    running_xor_next = running_xor_reg ^ rx_byte;
                    if (frame_start_reg == DELIM_SHORT)
                        addr_byte_next = rx_byte;
                    address_left_next = address_left_reg - ADDR_LEFT_W'(1);
                    if (address_left_reg == ADDR_LEFT_W'(1))
                        phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    running_xor_next = running_xor_reg ^ rx_byte;
                    cmd_next         = rx_byte;
                    phase_next       = PH_COUNT;
                end
                PH_COUNT:
                begin
                    running_xor_next = running_xor_reg ^ rx_byte;
                    count_next       = rx_byte;
                    if (rx_byte < MIN_COUNT)
                    begin
                        phase_next   = PH_DONE;
                        emit         = 1'b1;
                        emit_verdict = VERDICT_BADLEN;
                    end
                    else
                    begin
                        data_left_next = rx_byte - MIN_COUNT;
                        phase_next     = PH_ST1;
                    end
                end
                PH_ST1:
                begin
                    running_xor_next = running_xor_reg ^ rx_byte;
                    status_one_next  = rx_byte;
                    phase_next       = PH_ST2;
                end
                PH_ST2:
                begin
                    running_xor_next = running_xor_reg ^ rx_byte;
                    status_two_next  = rx_byte;
                    phase_next       = (data_left_reg != 8'd0) ? PH_DATA : PH_CHK;
                end
                PH_DATA:
                begin
                    running_xor_next = running_xor_reg ^ rx_byte;
                    data_left_next   = data_left_reg - 8'd1;
                    if (data_left_reg == 8'd1)
                        phase_next = PH_CHK;
                    emit      = 1'b1;
                    emit_kind = KIND_DATA;
                    emit_data = rx_byte;
                end
                PH_CHK:
                begin
                    phase_next   = PH_DONE;
                    emit         = 1'b1;
                    emit_verdict = (rx_byte == running_xor_reg) ? VERDICT_OK
                                                                : VERDICT_CHKERR;
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Fields reflect the frame as updated by this byte; a gap leaves them untouched.
    always_comb
    begin
        res_valid           = accept && emit;
        res.out_kind        = emit_kind;
        res.data_byte       = emit_data;
        res.verdict         = emit_verdict;
        res.command         = cmd_next;
        res.response_code   = status_one_next;
        res.device_status   = status_two_next;
        res.byte_count      = count_next;
        res.frame_delimiter = frame_start_next;
        res.short_address   = (frame_start_next == DELIM_SHORT) ? addr_byte_next : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_PRE;
            preamble_count_reg <= '0;
            address_left_reg   <= '0;
            frame_start_reg    <= '0;
            addr_byte_reg      <= '0;
            cmd_reg            <= '0;
            count_reg          <= '0;
            status_one_reg     <= '0;
            status_two_reg     <= '0;
            data_left_reg      <= '0;
            running_xor_reg    <= '0;
        end
        else if (accept)
        begin
            if (req_type == REQ_GAP)
            begin
                phase_reg          <= PH_PRE;
                preamble_count_reg <= '0;
                address_left_reg   <= '0;
                frame_start_reg    <= '0;
                addr_byte_reg      <= '0;
                cmd_reg            <= '0;
                count_reg          <= '0;
                status_one_reg     <= '0;
                status_two_reg     <= '0;
                data_left_reg      <= '0;
                running_xor_reg    <= '0;
            end
            else
            begin
                phase_reg          <= phase_next;
                preamble_count_reg <= preamble_count_next;
                address_left_reg   <= address_left_next;
                frame_start_reg    <= frame_start_next;
                addr_byte_reg      <= addr_byte_next;
                cmd_reg            <= cmd_next;
                count_reg          <= count_next;
                status_one_reg     <= status_one_next;
                status_two_reg     <= status_two_next;
                data_left_reg      <= data_left_next;
                running_xor_reg    <= running_xor_next;
            end
        end
    end

    a_gap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type == REQ_GAP)
        |=> (phase_reg == PH_PRE) && (preamble_count_reg == 5'd0))
        else $error("gap did not return parser to preamble");

    a_data_in_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.out_kind == KIND_DATA) |-> (phase_reg == PH_DATA))
        else $error("data result outside data phase");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == PH_DONE) |-> !res_valid)
        else $error("result after frame verdict");

    a_addr_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ADDR) |-> (address_left_reg != '0))
        else $error("address phase with no bytes left");

endmodule

/* sv/hrd_rsp_reg.sv */
// Result register: holds one response item toward the sink.
// Depends on hrd_pkg and hrd_rsp_if.
module hrd_rsp_reg
    import hrd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rsp_t      res,
    output logic      space,
    hrd_rsp_if.source rsp
);

    logic valid_reg;
    rsp_t data_reg;

    assign space = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (space)
            valid_reg <= push;
    end

    always_ff @(posedge clk)
    begin
        if (space && push)
            data_reg <= res;
    end

    assign rsp.valid           = valid_reg;
    assign rsp.out_kind        = data_reg.out_kind;
    assign rsp.data_byte       = data_reg.data_byte;
    assign rsp.verdict         = data_reg.verdict;
    assign rsp.command         = data_reg.command;
    assign rsp.response_code   = data_reg.response_code;
    assign rsp.device_status   = data_reg.device_status;
    assign rsp.byte_count      = data_reg.byte_count;
    assign rsp.frame_delimiter = data_reg.frame_delimiter;
    assign rsp.short_address   = data_reg.short_address;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("result pushed into full register");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> valid_reg)
        else $error("pushed result not presented");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && rsp.ready && !push |=> !valid_reg)
        else $error("taken result still presented");

endmodule

/* sv/hart_response_deframer_core.sv */
// HART response frame deframer, top level.
// Depends on hrd_pkg, hrd_if, hrd_parser and hrd_rsp_reg.
//
// Usage:
//   rx carries one item per transfer: a received byte (req_type 0) or an
//   end-of-burst gap (req_type 1). rsp carries zero or one result per rx
//   transfer: a payload data byte or the frame verdict, each with the frame
//   header fields received so far.
//   cfg_wr_en/cfg_wr_data write min_preamble; write it only while idle.
//   Throughput: one rx transfer per cycle unless rsp stalls (see Stall). The
//   per-byte state update is a single pass of the parser between its state
//   registers and the result register.
//   Latency: a result appears on rsp the cycle after its rx transfer.
//   Stall: while rsp holds an untaken result, rx.ready follows rsp.ready, so
//   a new byte is still taken in the cycle the held result is taken.
//   Reset: parser returns to the preamble phase with all frame fields zero,
//   min_preamble returns to 2, and rsp is empty.
module hart_response_deframer_core
    import hrd_pkg::*;
#(
    parameter int LONG_ADDRESS_BYTES = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [4:0] cfg_wr_data,
    hrd_rx_if.sink     rx,
    hrd_rsp_if.source  rsp
);

    logic [4:0] min_preamble_reg;
    logic       space;
    logic       accept;
    logic       res_valid;
    rsp_t       res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_preamble_reg <= MIN_PREAMBLE_RST;
        else if (cfg_wr_en)
            min_preamble_reg <= cfg_wr_data;
    end

    assign rx.ready = space;
    assign accept   = rx.valid && space;

    hrd_parser #(
        .LONG_ADDRESS_BYTES (LONG_ADDRESS_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .min_preamble (min_preamble_reg),
        .accept       (accept),
        .req_type     (rx.req_type),
        .rx_byte      (rx.rx_byte),
        .res_valid    (res_valid),
        .res          (res)
    );

    hrd_rsp_reg u_rsp_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .res   (res),
        .space (space),
        .rsp   (rsp)
    );

endmodule
